// ===== hdl/qap_pkg.sv =====
// Shared constants, types and helper functions of the quadtree atlas packer.
package qap_pkg;

	localparam int MAX_SIZE_LOG2 = 9;
	localparam int MIN_SIZE_LOG2 = 3;
	localparam int FACE_ID_BITS  = 16;

	localparam int LVL_W    = 4;
	localparam int FACE_W   = 16;
	localparam int POS_W    = 9;
	localparam int STATUS_W = 2;

	localparam logic [LVL_W-1:0] INIT_RESET = 4'd7;
	localparam logic [LVL_W-1:0] MAX_RESET  = 4'd9;

	// Configuration register indexes.
	localparam logic REG_INIT = 1'b0;
	localparam logic REG_MAX  = 1'b1;

	// Node codes held in the tree store.
	localparam logic [1:0] NODE_EMPTY = 2'd0;
	localparam logic [1:0] NODE_SPLIT = 2'd1;
	localparam logic [1:0] NODE_OCC   = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_PLACED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FRESH  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [LVL_W-1:0]    atlas_size_log2;
		logic [POS_W-1:0]    y_pos;
		logic [POS_W-1:0]    x_pos;
		logic [FACE_W-1:0]   face_out;
	} result_t;

	function automatic int node_count(input int levels);
		return ((1 << (2 * levels)) - 1) / 3;
	endfunction

	function automatic logic [LVL_W-1:0] clamp_level(input logic [LVL_W-1:0] v,
			input int lo, input int hi);
		if (int'(v) < lo) return LVL_W'(lo);
		if (int'(v) > hi) return LVL_W'(hi);
		return v;
	endfunction

	// Index of the top-left node at a depth of the full tree: the bit pattern 0101..01.
	function automatic logic [31:0] leftmost(input int depth);
		logic [31:0] r;
		r = '0;
		for (int k = 0; k < 16; k++) begin
			if (k < depth) r[2*k] = 1'b1;
		end
		return r;
	endfunction

endpackage

// ===== hdl/qap_node_mem.sv =====
// Single-port node store of the quadtree, two bits per node, registered read.
module qap_node_mem #(
	parameter int DEPTH = 5461,
	parameter int AW    = 13
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [1:0]    wdata,
	output logic [1:0]    rdata
);

	logic [1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end

endmodule

// ===== hdl/qap_walker.sv =====
// Placement sequencer: clears the store, walks the quadtree depth first and grows the atlas.
module qap_walker #(
	parameter int MAX_L     = qap_pkg::MAX_SIZE_LOG2,
	parameter int MIN_L     = qap_pkg::MIN_SIZE_LOG2,
	parameter int FACE_BITS = qap_pkg::FACE_ID_BITS,
	parameter int NODES     = 5461,
	parameter int IDX_W     = 13
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [qap_pkg::FACE_W-1:0]    in_face,
	input  logic [qap_pkg::LVL_W-1:0]     in_size,
	input  logic                          in_start,
	input  logic [qap_pkg::LVL_W-1:0]     init_cfg,
	input  logic [qap_pkg::LVL_W-1:0]     max_cfg,
	output logic                          res_valid,
	input  logic                          res_ready,
	output qap_pkg::result_t              res,
	output logic                          mem_we,
	output logic [IDX_W-1:0]              mem_addr,
	output logic [1:0]                    mem_wdata,
	input  logic [1:0]                    mem_rdata
);

	localparam int LW = qap_pkg::LVL_W;
	localparam int PW = MAX_L;
	localparam logic [qap_pkg::FACE_W-1:0] FACE_MASK = (FACE_BITS >= qap_pkg::FACE_W) ?
		{qap_pkg::FACE_W{1'b1}} : qap_pkg::FACE_W'((64'd1 << FACE_BITS) - 64'd1);
	localparam logic [LW-1:0] ROOT_RESET =
		qap_pkg::clamp_level(qap_pkg::INIT_RESET, MIN_L, MAX_L);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_CLEAR   = 4'd1;
	localparam logic [3:0] S_CHECK   = 4'd2;
	localparam logic [3:0] S_RD      = 4'd3;
	localparam logic [3:0] S_EVAL    = 4'd4;
	localparam logic [3:0] S_BACK    = 4'd5;
	localparam logic [3:0] S_UP      = 4'd6;
	localparam logic [3:0] S_GROW    = 4'd7;
	localparam logic [3:0] S_GROW_WR = 4'd8;
	localparam logic [3:0] S_DONE    = 4'd9;

	logic [3:0]                 state_q;
	logic                       busy_q;
	logic [IDX_W-1:0]           clr_q;
	logic [qap_pkg::FACE_W-1:0] face_q;
	logic [LW-1:0]              want_q;
	logic                       fresh_q;
	logic                       rej_q;
	logic [LW-1:0]              root_q;
	logic [IDX_W-1:0]           base_q;
	logic [IDX_W-1:0]           idx_q;
	logic [LW-1:0]              lvl_q;
	logic [PW-1:0]              x_q;
	logic [PW-1:0]              y_q;

	logic [LW-1:0]    eff_init;
	logic [LW-1:0]    eff_max;
	logic [LW-1:0]    limit;
	logic [IDX_W-1:0] idx_parent;
	logic [IDX_W-1:0] base_parent;
	logic [IDX_W-1:0] fresh_base;
	logic [1:0]       quad;
	logic [1:0]       quad_next;
	logic [PW-1:0]    lvl_mask;

	assign eff_init    = qap_pkg::clamp_level(init_cfg, MIN_L, MAX_L);
	assign eff_max     = qap_pkg::clamp_level(max_cfg, MIN_L, MAX_L);
	assign limit       = (eff_max > eff_init) ? eff_max : eff_init;
	assign idx_parent  = IDX_W'((idx_q - IDX_W'(1)) >> 2);
	assign base_parent = IDX_W'((base_q - IDX_W'(1)) >> 2);
	assign fresh_base  = IDX_W'(qap_pkg::leftmost(MAX_L - int'(eff_init)));
	assign quad        = 2'(idx_q - IDX_W'(1));
	assign quad_next   = quad + 2'd1;
	assign lvl_mask    = PW'(1) << lvl_q;

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);

	assign res.face_out        = face_q;
	assign res.x_pos           = qap_pkg::POS_W'(x_q);
	assign res.y_pos           = qap_pkg::POS_W'(y_q);
	assign res.atlas_size_log2 = root_q;
	assign res.status          = rej_q ? qap_pkg::ST_REJECT :
		(fresh_q ? qap_pkg::ST_FRESH : qap_pkg::ST_PLACED);

	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = idx_q;
		mem_wdata = qap_pkg::NODE_EMPTY;
		unique case (state_q)
			S_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
			end
			S_EVAL: begin
				if (lvl_q == want_q && mem_rdata == qap_pkg::NODE_EMPTY) begin
					mem_we    = 1'b1;
					mem_wdata = qap_pkg::NODE_OCC;
				end
			end
			S_UP: begin
				mem_we    = 1'b1;
				mem_wdata = qap_pkg::NODE_SPLIT;
			end
			S_GROW: mem_addr = base_q;
			S_GROW_WR: begin
				mem_we    = 1'b1;
				mem_addr  = base_parent;
				mem_wdata = (mem_rdata != qap_pkg::NODE_EMPTY) ?
					qap_pkg::NODE_SPLIT : qap_pkg::NODE_EMPTY;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			busy_q  <= 1'b0;
			clr_q   <= '0;
			fresh_q <= 1'b0;
			rej_q   <= 1'b0;
			root_q  <= ROOT_RESET;
			base_q  <= IDX_W'(qap_pkg::leftmost(MAX_L - int'(ROOT_RESET)));
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						face_q  <= in_face & FACE_MASK;
						want_q  <= in_size;
						fresh_q <= in_start;
						rej_q   <= 1'b0;
						busy_q  <= 1'b1;
						clr_q   <= '0;
						state_q <= in_start ? S_CLEAR : S_CHECK;
					end
				end
				S_CLEAR: begin
					if (clr_q == IDX_W'(NODES - 1)) begin
						// The sweep after reset keeps the reset root size.
						if (busy_q) begin
							root_q <= eff_init;
							base_q <= fresh_base;
						end
						state_q <= busy_q ? S_CHECK : S_IDLE;
					end else begin
						clr_q <= clr_q + IDX_W'(1);
					end
				end
				S_CHECK: begin
					x_q   <= '0;
					y_q   <= '0;
					idx_q <= base_q;
					lvl_q <= root_q;
					if (want_q < LW'(MIN_L) || want_q > limit) begin
						rej_q   <= 1'b1;
						state_q <= S_DONE;
					end else if (root_q < want_q) begin
						state_q <= S_GROW;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_EVAL;
				S_EVAL: begin
					if (lvl_q == want_q) begin
						if (mem_rdata == qap_pkg::NODE_EMPTY) begin
							if (lvl_q == root_q) begin
								state_q <= S_DONE;
							end else begin
								idx_q   <= idx_parent;
								lvl_q   <= lvl_q + LW'(1);
								state_q <= S_UP;
							end
						end else begin
							state_q <= S_BACK;
						end
					end else if (mem_rdata == qap_pkg::NODE_OCC) begin
						state_q <= S_BACK;
					end else begin
						// First child sits at the parent's corner, so the position holds.
						idx_q   <= IDX_W'({idx_q, 2'b01});
						lvl_q   <= lvl_q - LW'(1);
						state_q <= S_RD;
					end
				end
				S_BACK: begin
					if (lvl_q == root_q) begin
						state_q <= S_GROW;
					end else if (quad != 2'd3) begin
						idx_q   <= idx_q + IDX_W'(1);
						x_q     <= (x_q & ~lvl_mask) | (quad_next[0] ? lvl_mask : '0);
						y_q     <= (y_q & ~lvl_mask) | (quad_next[1] ? lvl_mask : '0);
						state_q <= S_RD;
					end else begin
						idx_q <= idx_parent;
						lvl_q <= lvl_q + LW'(1);
						x_q   <= x_q & ~lvl_mask;
						y_q   <= y_q & ~lvl_mask;
					end
				end
				S_UP: begin
					if (lvl_q == root_q) begin
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_parent;
						lvl_q <= lvl_q + LW'(1);
					end
				end
				S_GROW: begin
					if (root_q < eff_max && root_q < LW'(MAX_L)) begin
						state_q <= S_GROW_WR;
					end else begin
						fresh_q <= 1'b1;
						clr_q   <= '0;
						state_q <= S_CLEAR;
					end
				end
				S_GROW_WR: begin
					base_q  <= base_parent;
					root_q  <= root_q + LW'(1);
					state_q <= S_CHECK;
				end
				S_DONE: begin
					if (res_ready) begin
						busy_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/quadtree_atlas_packer.sv =====
// Top level of the quadtree atlas packer: configuration registers, output register, store.
//
// Blocks arrive on the slave stream: s_tdata carries the face id and the
// block's log2 edge, s_tuser carries the group-start flag. Every input beat
// yields exactly one output beat on the master stream with the face id, the
// block origin, the atlas edge after the placement and a status (placed,
// placed in a freshly opened atlas, rejected as out of range).
// The atlas state is a quadtree of two-bit node codes in a single-port
// memory with a registered read. A walk visits each node in two states
// (address, then evaluate), backs out and marks ancestors split level by
// level, and doubles the atlas through a grow read and a grow write.
// Opening a fresh atlas (group start, or full at the largest size) sweeps
// the whole store of NODES nodes (5461 at the default sizes), one node per
// cycle. The same sweep runs after reset; s_tready stays low meanwhile,
// while configuration writes are taken at any time.
// One block is in work at a time. A finished result waits in the output
// register while the next block is taken; if the receiver stalls, the
// walker holds its result until the register frees.
module quadtree_atlas_packer #(
	parameter int MAX_SIZE_LOG2 = qap_pkg::MAX_SIZE_LOG2,
	parameter int MIN_SIZE_LOG2 = qap_pkg::MIN_SIZE_LOG2,
	parameter int FACE_ID_BITS  = qap_pkg::FACE_ID_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [23:0]                s_tdata,  // face_id[15:0], size_log2[19:16], zero pad
	input  logic                       s_tuser,  // start_group
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// face_out[15:0], x_pos[24:16], y_pos[33:25], atlas_size_log2[37:34], status[39:38]
	output logic [39:0]                m_tdata,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [qap_pkg::LVL_W-1:0]  cfg_data
);

	// Full tree from the largest atlas edge down to the smallest block edge.
	localparam int TREE_LEVELS = MAX_SIZE_LOG2 - MIN_SIZE_LOG2 + 1;
	localparam int NODES       = qap_pkg::node_count(TREE_LEVELS);
	localparam int IDX_W       = $clog2(NODES);

	logic [qap_pkg::LVL_W-1:0] init_q;
	logic [qap_pkg::LVL_W-1:0] max_q;
	logic                      res_valid;
	logic                      res_ready;
	qap_pkg::result_t          res;
	logic                      mem_we;
	logic [IDX_W-1:0]          mem_addr;
	logic [1:0]                mem_wdata;
	logic [1:0]                mem_rdata;
	logic                      m_tvalid_q;
	qap_pkg::result_t          m_data_q;

	// Registers take effect at the next block; user writes only while idle; not enforced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= qap_pkg::INIT_RESET;
			max_q  <= qap_pkg::MAX_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				qap_pkg::REG_INIT: init_q <= cfg_data;
				qap_pkg::REG_MAX:  max_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	qap_walker #(
		.MAX_L     (MAX_SIZE_LOG2),
		.MIN_L     (MIN_SIZE_LOG2),
		.FACE_BITS (FACE_ID_BITS),
		.NODES     (NODES),
		.IDX_W     (IDX_W)
	) u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_face   (s_tdata[15:0]),
		.in_size   (s_tdata[19:16]),
		.in_start  (s_tuser),
		.init_cfg  (init_q),
		.max_cfg   (max_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata)
	);

	qap_node_mem #(
		.DEPTH (NODES),
		.AW    (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Output register: loads when empty or when the current beat leaves.
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) m_data_q <= res;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;

endmodule
